@@ src/cpatm_pkg.sv @@
// Shared types, constants and the control program of the attitude mixer.
`timescale 1ns / 1ps

package cpatm_pkg;

    // Field widths
    localparam int ANG_W      = 13;
    localparam int RATE_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int PULSE_W    = 11;
    localparam int ERR_W      = ANG_W + 1;
    localparam int INT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int MUL_A_W = INT_W + 1;
    localparam int MUL_B_W = GAIN_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int W_W     = 50;
    localparam int ACC_W   = 56;
    localparam int DIV_W   = 34;
    localparam int QUO_W   = 8;
    localparam int CNT_W   = 3;
    localparam int STEP_W  = 4;

    // Fixed-point constants
    localparam int STEPS_PER_SEC = 200;
    localparam int REF_DEN       = 51200;
    localparam int THRUST_DEN    = 204800;
    localparam int PULSE_BASE    = 1500;
    localparam int PULSE_SPAN    = 160;
    localparam int DIV_SCALE     = THRUST_DEN / PULSE_SPAN;
    localparam int DIV_HI        = DIV_SCALE * (2 ** (QUO_W - 1));

    // Register reset values
    localparam int RST_KP_GAIN = 1280;
    localparam int RST_KI_GAIN = 256;
    localparam int RST_TRIM    = 2560;
    localparam int RST_LIMIT   = 10240;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLL_TARGET   = 3'd0,
        CFG_PITCH_TARGET  = 3'd1,
        CFG_KP_ROLL_GAIN  = 3'd2,
        CFG_KI_ROLL_GAIN  = 3'd3,
        CFG_KP_PITCH_GAIN = 3'd4,
        CFG_KI_PITCH_GAIN = 3'd5,
        CFG_TRIM_THRUST   = 3'd6,
        CFG_THRUST_LIMIT  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [ANG_W-1:0]  roll_target;
        logic [ANG_W-1:0]  pitch_target;
        logic [GAIN_W-1:0] kp_roll_gain;
        logic [GAIN_W-1:0] ki_roll_gain;
        logic [GAIN_W-1:0] kp_pitch_gain;
        logic [GAIN_W-1:0] ki_pitch_gain;
        logic [GAIN_W-1:0] trim_thrust;
        logic [GAIN_W-1:0] thrust_limit;
    } t_cfg;

    typedef struct packed {
        logic [ANG_W-1:0]  roll_angle;
        logic [ANG_W-1:0]  pitch_angle;
        logic [RATE_W-1:0] roll_rate;
        logic [RATE_W-1:0] pitch_rate;
    } t_in_req;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_first;
        logic [PULSE_W-1:0] pulse_second;
        logic [PULSE_W-1:0] pulse_third;
    } t_out_req;

    typedef enum logic [1:0] {
        SLOT_FIRST  = 2'd0,
        SLOT_SECOND = 2'd1,
        SLOT_THIRD  = 2'd2
    } t_slot;

    typedef struct packed {
        logic               valid;
        t_slot              slot;
        logic [PULSE_W-1:0] pulse;
    } t_div_res;

    // Micro-op fields
    typedef enum logic [2:0] {
        MA_E_ROLL    = 3'd0,
        MA_E_PITCH   = 3'd1,
        MA_PROD      = 3'd2,
        MA_INT_ROLL  = 3'd3,
        MA_INT_PITCH = 3'd4,
        MA_RATE_P    = 3'd5,
        MA_RATE_Q    = 3'd6
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_KP_ROLL  = 3'd0,
        MB_KP_PITCH = 3'd1,
        MB_KI_ROLL  = 3'd2,
        MB_KI_PITCH = 3'd3,
        MB_STEP     = 3'd4,
        MB_REF      = 3'd5
    } t_mul_b;

    typedef enum logic [1:0] {
        AB_ZERO = 2'd0,
        AB_ACC  = 2'd1,
        AB_TRIM = 2'd2
    } t_acc_base;

    typedef enum logic [2:0] {
        AO_NONE  = 3'd0,
        AO_PROD  = 3'd1,
        AO_W0X10 = 3'd2,
        AO_W1X10 = 3'd3,
        AO_W0X5  = 3'd4,
        AO_W1X5  = 3'd5
    } t_acc_opnd;

    // Hold conditions: the step repeats while its condition is true
    typedef enum logic [1:0] {
        COND_NONE    = 2'd0,
        COND_IN      = 2'd1,
        COND_DIV     = 2'd2,
        COND_DIV_OUT = 2'd3
    } t_cond;

    typedef struct packed {
        logic              accept;
        logic              mul_en;
        t_mul_a            mul_a;
        t_mul_b            mul_b;
        logic              acc_en;
        t_acc_base         acc_base;
        t_acc_opnd         acc_opnd;
        logic              acc_sub;
        logic              st_w0;
        logic              st_w1;
        logic              div_start;
        t_slot             div_slot;
        logic              emit;
        t_cond             cond;
        logic              jump_en;
        logic [STEP_W-1:0] jump_to;
    } t_ctrl;

    localparam logic [STEP_W-1:0] STEP_ACCEPT = '0;

    localparam t_ctrl CTRL_NOP = '{
        accept:    1'b0,
        mul_en:    1'b0,
        mul_a:     MA_E_ROLL,
        mul_b:     MB_KP_ROLL,
        acc_en:    1'b0,
        acc_base:  AB_ZERO,
        acc_opnd:  AO_NONE,
        acc_sub:   1'b0,
        st_w0:     1'b0,
        st_w1:     1'b0,
        div_start: 1'b0,
        div_slot:  SLOT_FIRST,
        emit:      1'b0,
        cond:      COND_NONE,
        jump_en:   1'b0,
        jump_to:   STEP_ACCEPT
    };

    // Control program: one word per step
    function automatic t_ctrl ucode_word(input logic [STEP_W-1:0] step);
        t_ctrl cw;
        cw = CTRL_NOP;
        case (step)
            4'd0: begin
                cw.accept = 1'b1;
                cw.cond   = COND_IN;
            end
            4'd1: begin
                cw.mul_en = 1'b1; cw.mul_a = MA_E_ROLL; cw.mul_b = MB_KP_ROLL;
            end
            4'd2: begin
                cw.mul_en = 1'b1; cw.mul_a = MA_PROD; cw.mul_b = MB_STEP;
            end
            4'd3: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_ZERO;
                cw.acc_opnd = AO_PROD; cw.acc_sub = 1'b1;
                cw.mul_en = 1'b1; cw.mul_a = MA_INT_ROLL; cw.mul_b = MB_KI_ROLL;
            end
            4'd4: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_ACC;
                cw.acc_opnd = AO_PROD; cw.acc_sub = 1'b1;
                cw.mul_en = 1'b1; cw.mul_a = MA_RATE_P; cw.mul_b = MB_REF;
            end
            4'd5: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_ACC; cw.acc_opnd = AO_PROD;
                cw.st_w0 = 1'b1;
                cw.mul_en = 1'b1; cw.mul_a = MA_E_PITCH; cw.mul_b = MB_KP_PITCH;
            end
            4'd6: begin
                cw.mul_en = 1'b1; cw.mul_a = MA_PROD; cw.mul_b = MB_STEP;
            end
            4'd7: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_ZERO;
                cw.acc_opnd = AO_PROD; cw.acc_sub = 1'b1;
                cw.mul_en = 1'b1; cw.mul_a = MA_INT_PITCH; cw.mul_b = MB_KI_PITCH;
            end
            4'd8: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_ACC;
                cw.acc_opnd = AO_PROD; cw.acc_sub = 1'b1;
                cw.mul_en = 1'b1; cw.mul_a = MA_RATE_Q; cw.mul_b = MB_REF;
            end
            4'd9: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_ACC; cw.acc_opnd = AO_PROD;
                cw.st_w1 = 1'b1;
            end
            4'd10: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_TRIM;
                cw.acc_opnd = AO_W0X10; cw.acc_sub = 1'b1;
            end
            4'd11: begin
                cw.div_start = 1'b1; cw.div_slot = SLOT_FIRST;
                cw.acc_en = 1'b1; cw.acc_base = AB_TRIM;
                cw.acc_opnd = AO_W1X10; cw.acc_sub = 1'b1;
            end
            4'd12: begin
                cw.cond = COND_DIV;
                cw.div_start = 1'b1; cw.div_slot = SLOT_SECOND;
                cw.acc_en = 1'b1; cw.acc_base = AB_TRIM;
                cw.acc_opnd = AO_W0X5; cw.acc_sub = 1'b1;
            end
            4'd13: begin
                cw.acc_en = 1'b1; cw.acc_base = AB_ACC;
                cw.acc_opnd = AO_W1X5; cw.acc_sub = 1'b1;
            end
            4'd14: begin
                cw.cond = COND_DIV;
                cw.div_start = 1'b1; cw.div_slot = SLOT_THIRD;
            end
            4'd15: begin
                cw.cond    = COND_DIV_OUT;
                cw.emit    = 1'b1;
                cw.jump_en = 1'b1;
                cw.jump_to = STEP_ACCEPT;
            end
            default: begin
                cw = CTRL_NOP;
            end
        endcase
        return cw;
    endfunction

endpackage

@@ src/cpatm_if.sv @@
// Request channel interfaces: sensor input, pulse output and register write.
`timescale 1ns / 1ps

interface cpatm_in_if;
    import cpatm_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpatm_out_if;
    import cpatm_pkg::*;
    logic     valid;
    logic     ready;
    t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpatm_cfg_if;
    import cpatm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/cascaded_pi_attitude_thrust_mixer_unit.sv @@
// Top level of the cascaded PI attitude controller with three-thruster mixer.
// Each accepted request carries roll, pitch (rad x 1024) and roll and pitch rate
// (rad/s x 1024). On accept the block advances two saturating 32-bit angle-error
// integrators, then a 16-step control program runs an outer PI loop per axis to
// form rate references, takes the rate errors through the fixed mixer rows
// (10,0), (0,10) and (5,5), subtracts them from the trim thrust and maps each
// thrust, clamped to 0..thrust_limit, to a 1500..1660 us pulse. All products
// go through one shared 33x18 multiplier and all three pulses through one
// bit-serial divider. Each division runs a clamp check, eight quotient bits and
// a hand-over; a thrust that clamps skips the quotient bits. Three steps of the
// program wait on the divider, and the final step also waits while an earlier
// result is unread. The program returns to its accept step in the cycle after
// the result is loaded, so a new request is taken only once the last one has
// run through the program. The result sits in an output register, so the
// block takes the next request while it waits to be read. Registers are
// written through the configuration channel, which is always ready; write
// them only while idle.
`timescale 1ns / 1ps

module cascaded_pi_attitude_thrust_mixer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpatm_in_if.sink     i_in,
    cpatm_out_if.source  o_out,
    cpatm_cfg_if.sink    i_cfg
);
    import cpatm_pkg::*;

    t_cfg               r_cfg;
    t_ctrl              ctrl;
    logic               in_ready;
    logic               div_busy;
    logic               out_busy;
    t_div_res           div_res;
    logic signed [ACC_W-1:0] acc;
    logic [PULSE_W-1:0] r_stage_first;
    logic [PULSE_W-1:0] r_stage_second;
    logic [PULSE_W-1:0] r_stage_third;
    logic               r_out_valid;
    t_out_req           r_out;

    // Configuration registers: every write is taken at once
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roll_target   <= '0;
            r_cfg.pitch_target  <= '0;
            r_cfg.kp_roll_gain  <= GAIN_W'(RST_KP_GAIN);
            r_cfg.ki_roll_gain  <= GAIN_W'(RST_KI_GAIN);
            r_cfg.kp_pitch_gain <= GAIN_W'(RST_KP_GAIN);
            r_cfg.ki_pitch_gain <= GAIN_W'(RST_KI_GAIN);
            r_cfg.trim_thrust   <= GAIN_W'(RST_TRIM);
            r_cfg.thrust_limit  <= GAIN_W'(RST_LIMIT);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ROLL_TARGET:   r_cfg.roll_target   <= i_cfg.data[ANG_W-1:0];
                CFG_PITCH_TARGET:  r_cfg.pitch_target  <= i_cfg.data[ANG_W-1:0];
                CFG_KP_ROLL_GAIN:  r_cfg.kp_roll_gain  <= i_cfg.data;
                CFG_KI_ROLL_GAIN:  r_cfg.ki_roll_gain  <= i_cfg.data;
                CFG_KP_PITCH_GAIN: r_cfg.kp_pitch_gain <= i_cfg.data;
                CFG_KI_PITCH_GAIN: r_cfg.ki_pitch_gain <= i_cfg.data;
                CFG_TRIM_THRUST:   r_cfg.trim_thrust   <= i_cfg.data;
                CFG_THRUST_LIMIT:  r_cfg.thrust_limit  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Hold the program at its final step while the last result is unread
    assign out_busy   = r_out_valid && !o_out.ready;
    assign i_in.ready = in_ready;

    cpatm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_div_busy (div_busy),
        .i_out_busy (out_busy),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    cpatm_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in.data),
        .i_ctrl  (ctrl),
        .o_acc   (acc)
    );

    cpatm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ctrl.div_start),
        .i_slot   (ctrl.div_slot),
        .i_thrust (acc),
        .i_limit  (r_cfg.thrust_limit),
        .o_busy   (div_busy),
        .o_res    (div_res)
    );

    // Collect the three pulses as the divider hands them over
    always_ff @(posedge i_clk) begin
        if (div_res.valid) begin
            case (div_res.slot)
                SLOT_FIRST:  r_stage_first  <= div_res.pulse;
                SLOT_SECOND: r_stage_second <= div_res.pulse;
                SLOT_THIRD:  r_stage_third  <= div_res.pulse;
                default: begin
                end
            endcase
        end
    end

    // Output register: load on emit, drop valid once the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out.pulse_first  <= r_stage_first;
            r_out.pulse_second <= r_stage_second;
            r_out.pulse_third  <= r_stage_third;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

@@ src/cpatm_seq.sv @@
// Microcode sequencer: step counter, program lookup and hold conditions.
`timescale 1ns / 1ps

module cpatm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_div_busy,
    input  logic           i_out_busy,
    output logic           o_in_ready,
    output cpatm_pkg::t_ctrl o_ctrl
);
    import cpatm_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             cw;
    logic              hold;

    assign cw         = ucode_word(r_step);
    assign o_in_ready = cw.accept;

    always_comb begin
        case (cw.cond)
            COND_NONE:    hold = 1'b0;
            COND_IN:      hold = !i_in_valid;
            COND_DIV:     hold = i_div_busy;
            COND_DIV_OUT: hold = i_div_busy || i_out_busy;
            default:      hold = 1'b0;
        endcase
    end

    // Suppress every action of a held step
    assign o_ctrl = hold ? CTRL_NOP : cw;

    always_comb begin
        if (hold) begin
            n_step = r_step;
        end else if (cw.jump_en) begin
            n_step = cw.jump_to;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.div_start |-> !i_div_busy)
        else $error("divider started while busy");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.emit |-> (!i_out_busy && !i_div_busy))
        else $error("result emitted over a pending request");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.accept |-> i_in_valid)
        else $error("request taken without valid");

endmodule

@@ src/cpatm_dpath.sv @@
// Datapath: error integrators, shared multiplier, accumulator and rate errors.
`timescale 1ns / 1ps

module cpatm_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cpatm_pkg::t_cfg                       i_cfg,
    input  cpatm_pkg::t_in_req                    i_in,
    input  cpatm_pkg::t_ctrl                      i_ctrl,
    output logic signed [cpatm_pkg::ACC_W-1:0]    o_acc
);
    import cpatm_pkg::*;

    function automatic logic signed [INT_W-1:0] sat_add(
        input logic signed [INT_W-1:0] acc,
        input logic signed [ERR_W-1:0] e
    );
        logic signed [INT_W:0] s;
        s = {acc[INT_W-1], acc} + {{(INT_W + 1 - ERR_W){e[ERR_W-1]}}, e};
        if (s[INT_W] != s[INT_W-1]) begin
            sat_add = s[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}}
                               : {1'b0, {(INT_W - 1){1'b1}}};
        end else begin
            sat_add = s[INT_W-1:0];
        end
    endfunction

    logic signed [ERR_W-1:0]   e_roll;
    logic signed [ERR_W-1:0]   e_pitch;
    logic signed [ERR_W-1:0]   r_e_roll;
    logic signed [ERR_W-1:0]   r_e_pitch;
    logic signed [INT_W-1:0]   r_int_roll;
    logic signed [INT_W-1:0]   r_int_pitch;
    logic signed [RATE_W-1:0]  r_rate_p;
    logic signed [RATE_W-1:0]  r_rate_q;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   r_trim_den;
    logic signed [W_W-1:0]     r_w0;
    logic signed [W_W-1:0]     r_w1;
    logic signed [ACC_W-1:0]   w0e;
    logic signed [ACC_W-1:0]   w1e;
    logic signed [ACC_W-1:0]   base;
    logic signed [ACC_W-1:0]   opnd;

    assign e_roll  = {i_cfg.roll_target[ANG_W-1], i_cfg.roll_target}
                   - {i_in.roll_angle[ANG_W-1], i_in.roll_angle};
    assign e_pitch = {i_cfg.pitch_target[ANG_W-1], i_cfg.pitch_target}
                   - {i_in.pitch_angle[ANG_W-1], i_in.pitch_angle};

    // Latch the request and advance the integrators on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_roll  <= '0;
            r_int_pitch <= '0;
        end else if (i_ctrl.accept) begin
            r_int_roll  <= sat_add(r_int_roll, e_roll);
            r_int_pitch <= sat_add(r_int_pitch, e_pitch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_e_roll  <= e_roll;
            r_e_pitch <= e_pitch;
            r_rate_p  <= i_in.roll_rate;
            r_rate_q  <= i_in.pitch_rate;
        end
    end

    always_comb begin
        case (i_ctrl.mul_a)
            MA_E_ROLL:    mul_a = {{(MUL_A_W - ERR_W){r_e_roll[ERR_W-1]}}, r_e_roll};
            MA_E_PITCH:   mul_a = {{(MUL_A_W - ERR_W){r_e_pitch[ERR_W-1]}}, r_e_pitch};
            MA_PROD:      mul_a = r_prod[MUL_A_W-1:0];
            MA_INT_ROLL:  mul_a = {r_int_roll[INT_W-1], r_int_roll};
            MA_INT_PITCH: mul_a = {r_int_pitch[INT_W-1], r_int_pitch};
            MA_RATE_P:    mul_a = {{(MUL_A_W - RATE_W){r_rate_p[RATE_W-1]}}, r_rate_p};
            MA_RATE_Q:    mul_a = {{(MUL_A_W - RATE_W){r_rate_q[RATE_W-1]}}, r_rate_q};
            default:      mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.mul_b)
            MB_KP_ROLL:  mul_b = {2'b00, i_cfg.kp_roll_gain};
            MB_KP_PITCH: mul_b = {2'b00, i_cfg.kp_pitch_gain};
            MB_KI_ROLL:  mul_b = {2'b00, i_cfg.ki_roll_gain};
            MB_KI_PITCH: mul_b = {2'b00, i_cfg.ki_pitch_gain};
            MB_STEP:     mul_b = MUL_B_W'(STEPS_PER_SEC);
            MB_REF:      mul_b = MUL_B_W'(REF_DEN);
            default:     mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign w0e = {{(ACC_W - W_W){r_w0[W_W-1]}}, r_w0};
    assign w1e = {{(ACC_W - W_W){r_w1[W_W-1]}}, r_w1};

    always_comb begin
        case (i_ctrl.acc_base)
            AB_ZERO: base = '0;
            AB_ACC:  base = r_acc;
            AB_TRIM: base = r_trim_den;
            default: base = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.acc_opnd)
            AO_NONE:  opnd = '0;
            AO_PROD:  opnd = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
            AO_W0X10: opnd = (w0e <<< 3) + (w0e <<< 1);
            AO_W1X10: opnd = (w1e <<< 3) + (w1e <<< 1);
            AO_W0X5:  opnd = (w0e <<< 2) + w0e;
            AO_W1X5:  opnd = (w1e <<< 2) + w1e;
            default:  opnd = '0;
        endcase
    end

    assign n_acc = i_ctrl.acc_sub ? (base - opnd) : (base + opnd);

    always_ff @(posedge i_clk) begin
        r_trim_den <= ACC_W'(i_cfg.trim_thrust) * ACC_W'(THRUST_DEN);
        if (i_ctrl.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_ctrl.acc_en) begin
            r_acc <= n_acc;
        end
        if (i_ctrl.st_w0) begin
            r_w0 <= n_acc[W_W-1:0];
        end
        if (i_ctrl.st_w1) begin
            r_w1 <= n_acc[W_W-1:0];
        end
    end

    assign o_acc = r_acc;

endmodule

@@ src/cpatm_div.sv @@
// Pulse mapper: clamps a thrust numerator and divides it down, one bit a cycle.
`timescale 1ns / 1ps

module cpatm_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  cpatm_pkg::t_slot                   i_slot,
    input  logic signed [cpatm_pkg::ACC_W-1:0] i_thrust,
    input  logic [cpatm_pkg::GAIN_W-1:0]       i_limit,
    output logic                               o_busy,
    output cpatm_pkg::t_div_res                o_res
);
    import cpatm_pkg::*;

    typedef enum logic [2:0] {
        DS_IDLE  = 3'b001,
        DS_CHECK = 3'b010,
        DS_ITER  = 3'b100
    } t_div_state;

    t_div_state              r_state;
    logic signed [ACC_W-1:0] r_t;
    t_slot                   r_slot;
    logic [DIV_W-1:0]        r_top;
    logic [DIV_W-1:0]        r_dsh0;
    logic [DIV_W-1:0]        r_rem;
    logic [DIV_W-1:0]        r_dsh;
    logic [QUO_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_res_valid;
    t_slot                   r_res_slot;
    logic [PULSE_W-1:0]      r_res_pulse;
    logic signed [ACC_W-1:0] top_ext;
    logic [DIV_W:0]          diff;
    logic [QUO_W-1:0]        quo_next;

    assign top_ext  = {{(ACC_W - DIV_W){1'b0}}, r_top};
    assign diff     = {1'b0, r_rem} - {1'b0, r_dsh};
    assign quo_next = {r_quo[QUO_W-2:0], ~diff[DIV_W]};

    always_ff @(posedge i_clk) begin
        r_top  <= DIV_W'(i_limit) * DIV_W'(THRUST_DEN);
        r_dsh0 <= DIV_W'(i_limit) * DIV_W'(DIV_HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DS_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                DS_IDLE: begin
                    if (i_start) begin
                        r_state <= DS_CHECK;
                    end
                end
                DS_CHECK: begin
                    if (i_limit == '0 || r_t <= 0 || r_t >= top_ext) begin
                        r_res_valid <= 1'b1;
                        r_state     <= DS_IDLE;
                    end else begin
                        r_state <= DS_ITER;
                    end
                end
                DS_ITER: begin
                    if (r_cnt == '0) begin
                        r_res_valid <= 1'b1;
                        r_state     <= DS_IDLE;
                    end
                end
                default: begin
                    r_state <= DS_IDLE;
                end
            endcase
        end
    end

    // Latch the operand, then clamp or run one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            DS_IDLE: begin
                if (i_start) begin
                    r_t        <= i_thrust;
                    r_slot     <= i_slot;
                    r_res_slot <= i_slot;
                end
            end
            DS_CHECK: begin
                r_rem <= r_t[DIV_W-1:0];
                r_dsh <= r_dsh0;
                r_quo <= '0;
                r_cnt <= CNT_W'(QUO_W - 1);
                if (i_limit == '0 || r_t <= 0) begin
                    r_res_pulse <= PULSE_W'(PULSE_BASE);
                end else begin
                    r_res_pulse <= PULSE_W'(PULSE_BASE + PULSE_SPAN);
                end
            end
            DS_ITER: begin
                if (!diff[DIV_W]) begin
                    r_rem <= diff[DIV_W-1:0];
                end
                r_dsh       <= r_dsh >> 1;
                r_quo       <= quo_next;
                r_cnt       <= r_cnt - 1'b1;
                r_res_pulse <= PULSE_W'(PULSE_BASE) + PULSE_W'(quo_next);
                r_res_slot  <= r_slot;
            end
            default: begin
                r_res_slot <= r_slot;
            end
        endcase
    end

    assign o_busy      = (r_state != DS_IDLE) || r_res_valid;
    assign o_res.valid = r_res_valid;
    assign o_res.slot  = r_res_slot;
    assign o_res.pulse = r_res_pulse;

    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DS_ITER && r_cnt == '0) |=> r_res_valid)
        else $error("division finished without a result");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_res_pulse >= PULSE_W'(PULSE_BASE)
                      && r_res_pulse <= PULSE_W'(PULSE_BASE + PULSE_SPAN)))
        else $error("pulse outside its span");

    a_start_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DS_IDLE && i_start) |=> (r_state == DS_CHECK))
        else $error("start did not reach the clamp check");

endmodule
